[rtl/triangle_scanline_span_rasterizer_macros.svh]
// ----------------------------------------------------------------------------
// Triangle scanline span rasterizer: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_SCANLINE_SPAN_RASTERIZER_MACROS_SVH
`define TRIANGLE_SCANLINE_SPAN_RASTERIZER_MACROS_SVH

// same-cycle implication
`define TSR_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TSR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/tsr_pkg.sv]
// ----------------------------------------------------------------------------
// tsr_pkg
// Widths, types and controller/datapath command and status for the rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

package tsr_pkg;

	localparam int X_BITS      = 7;
	localparam int Y_BITS      = 5;
	localparam int COLOUR_BITS = 8;
	localparam int ERR_BITS    = X_BITS + 3;

	typedef logic [X_BITS-1:0]             xcoord_t;
	typedef logic [Y_BITS-1:0]             ycoord_t;
	typedef logic [COLOUR_BITS-1:0]        colour_t;
	typedef logic signed [ERR_BITS-1:0]    err_t;

	typedef enum logic [1:0] {
		DIR_NONE = 2'd0,
		DIR_INC  = 2'd1,
		DIR_DEC  = 2'd2
	} dir_t;

	typedef struct packed {
		logic accept;
		logic load_long;
		logic load_short_upper;
		logic load_short_lower;
		logic step;
		logic emit;
		logic flat;
		logic last;
		logic row_inc;
	} tsr_cmd_t;

	typedef struct packed {
		logic in_fire;
		logic y01_eq;
		logic y12_eq;
		logic row_at_y1;
		logic row_at_y2;
		logic walk_done;
		logic out_free;
	} tsr_sts_t;

endpackage

`default_nettype wire

[rtl/tsr_ifs.sv]
// ----------------------------------------------------------------------------
// tsr_tri_if / tsr_span_if
// Valid/ready channels for triangles in and spans out.
// ----------------------------------------------------------------------------
`default_nettype none

interface tsr_tri_if;
	import tsr_pkg::*;
	logic    valid;
	logic    ready;
	xcoord_t vertex_a_x;
	ycoord_t vertex_a_y;
	xcoord_t vertex_b_x;
	ycoord_t vertex_b_y;
	xcoord_t vertex_c_x;
	ycoord_t vertex_c_y;
	colour_t fill_colour;

	modport source (output valid, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
		vertex_c_x, vertex_c_y, fill_colour, input ready);
	modport sink (input valid, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
		vertex_c_x, vertex_c_y, fill_colour, output ready);
endinterface

interface tsr_span_if;
	import tsr_pkg::*;
	logic    valid;
	logic    ready;
	ycoord_t span_row;
	xcoord_t span_long_x;
	xcoord_t span_short_x;
	colour_t span_colour;
	logic    span_last;

	modport source (output valid, span_row, span_long_x, span_short_x, span_colour,
		span_last, input ready);
	modport sink (input valid, span_row, span_long_x, span_short_x, span_colour,
		span_last, output ready);
endinterface

`default_nettype wire

[rtl/tsr_edge.sv]
// ----------------------------------------------------------------------------
// tsr_edge
// Bresenham edge walker: one error-term step per cycle until the edge leaves
// the current row or reaches its end point; reports the last column held.
// ----------------------------------------------------------------------------
`default_nettype none

module tsr_edge (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  tsr_pkg::xcoord_t x0,
	input  tsr_pkg::ycoord_t y0,
	input  tsr_pkg::xcoord_t x1,
	input  tsr_pkg::ycoord_t y1,
	input  logic            step,
	input  tsr_pkg::ycoord_t row,
	output logic            done,
	output tsr_pkg::xcoord_t held
);
	import tsr_pkg::*;

	xcoord_t px_q, dx_q, ex_q, held_q;
	ycoord_t py_q, dy_q, ey_q;
	err_t    e_q;
	dir_t    dir_q;

	logic                      past_row, at_end, xstep, ystep;
	logic signed [ERR_BITS:0]  e2, pdx, pdy, e_next;
	xcoord_t                   dx_new;
	ycoord_t                   dy_new;
	dir_t                      dir_new;

	assign past_row = py_q > row;
	assign at_end   = (px_q == ex_q) && (py_q == ey_q);
	assign done     = past_row || at_end;
	assign held     = past_row ? held_q : px_q;

	assign e2     = {e_q, 1'b0};
	assign pdx    = {{(ERR_BITS + 1 - X_BITS){1'b0}}, dx_q};
	assign pdy    = {{(ERR_BITS + 1 - Y_BITS){1'b0}}, dy_q};
	assign xstep  = e2 >= -pdy;
	assign ystep  = e2 <= pdx;
	assign e_next = {e_q[ERR_BITS-1], e_q} - (xstep ? pdy : '0) + (ystep ? pdx : '0);

	assign dx_new  = (x1 > x0) ? x1 - x0 : x0 - x1;
	assign dy_new  = y1 - y0;
	assign dir_new = (x1 > x0) ? DIR_INC : ((x1 < x0) ? DIR_DEC : DIR_NONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_q   <= '0;
			py_q   <= '0;
			e_q    <= '0;
			dx_q   <= '0;
			dy_q   <= '0;
			dir_q  <= DIR_NONE;
			ex_q   <= '0;
			ey_q   <= '0;
			held_q <= '0;
		end else if (load) begin
			px_q   <= x0;
			py_q   <= y0;
			dx_q   <= dx_new;
			dy_q   <= dy_new;
			dir_q  <= dir_new;
			ex_q   <= x1;
			ey_q   <= y1;
			held_q <= x0;
			e_q    <= err_t'({{(ERR_BITS - X_BITS){1'b0}}, dx_new})
				- err_t'({{(ERR_BITS - Y_BITS){1'b0}}, dy_new});
		end else if (step && !done) begin
			held_q <= px_q;
			e_q    <= e_next[ERR_BITS-1:0];
			if (xstep) begin
				case (dir_q)
					DIR_INC: px_q <= px_q + 1'b1;
					DIR_DEC: px_q <= px_q - 1'b1;
					default: px_q <= px_q;
				endcase
			end
			if (ystep) begin
				py_q <= py_q + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/tsr_datapath.sv]
// ----------------------------------------------------------------------------
// tsr_datapath
// Vertex sort and hold, row counter, long and short edge walkers, span
// output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "triangle_scanline_span_rasterizer_macros.svh"

module tsr_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  tsr_pkg::tsr_cmd_t cmd,
	output tsr_pkg::tsr_sts_t sts,
	tsr_tri_if.sink           triangle,
	tsr_span_if.source        span
);
	import tsr_pkg::*;

	xcoord_t x0_q, x1_q, x2_q;
	ycoord_t y0_q, y1_q, y2_q, row_q;
	colour_t colour_q;

	xcoord_t s0x, s1x, s2x;
	ycoord_t s0y, s1y, s2y;

	logic    in_fire;
	logic    long_done, short_done;
	xcoord_t long_held, short_held;
	logic    short_load;
	xcoord_t sh_x0, sh_x1;
	ycoord_t sh_y0;

	logic    out_valid_q, out_last_q;
	ycoord_t out_row_q;
	xcoord_t out_long_q, out_short_q;
	colour_t out_colour_q;
	logic    out_free;
	xcoord_t long_lo, long_hi;

	assign triangle.ready = cmd.accept;
	assign in_fire        = triangle.valid && cmd.accept;

	// sort by row
	always_comb begin
		xcoord_t tx;
		ycoord_t ty;
		tx = '0;
		ty = '0;
		s0x = triangle.vertex_a_x; s0y = triangle.vertex_a_y;
		s1x = triangle.vertex_b_x; s1y = triangle.vertex_b_y;
		s2x = triangle.vertex_c_x; s2y = triangle.vertex_c_y;
		if (s1y < s0y) begin
			tx = s0x; ty = s0y; s0x = s1x; s0y = s1y; s1x = tx; s1y = ty;
		end
		if (s2y < s0y) begin
			tx = s0x; ty = s0y; s0x = s2x; s0y = s2y; s2x = tx; s2y = ty;
		end
		if (s2y < s1y) begin
			tx = s1x; ty = s1y; s1x = s2x; s1y = s2y; s2x = tx; s2y = ty;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			x0_q     <= s0x; y0_q <= s0y;
			x1_q     <= s1x; y1_q <= s1y;
			x2_q     <= s2x; y2_q <= s2y;
			colour_q <= triangle.fill_colour;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
		end else if (cmd.load_long) begin
			row_q <= y0_q;
		end else if (cmd.row_inc) begin
			row_q <= row_q + 1'b1;
		end
	end

	tsr_edge u_long (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (cmd.load_long),
		.x0     (x0_q),
		.y0     (y0_q),
		.x1     (x2_q),
		.y1     (y2_q),
		.step   (cmd.step),
		.row    (row_q),
		.done   (long_done),
		.held   (long_held)
	);

	assign short_load = cmd.load_short_upper || cmd.load_short_lower;
	assign sh_x0      = cmd.load_short_upper ? x0_q : x1_q;
	assign sh_y0      = cmd.load_short_upper ? y0_q : y1_q;
	assign sh_x1      = cmd.load_short_upper ? x1_q : x2_q;

	tsr_edge u_short (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (short_load),
		.x0     (sh_x0),
		.y0     (sh_y0),
		.x1     (sh_x1),
		.y1     (cmd.load_short_upper ? y1_q : y2_q),
		.step   (cmd.step),
		.row    (row_q),
		.done   (short_done),
		.held   (short_held)
	);

	assign out_free = !out_valid_q || span.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit || cmd.flat) begin
			out_valid_q <= 1'b1;
		end else if (span.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_row_q    <= row_q;
			out_long_q   <= long_held;
			out_short_q  <= short_held;
			out_colour_q <= colour_q;
			out_last_q   <= cmd.last;
		end else if (cmd.flat) begin
			out_row_q    <= y2_q;
			out_long_q   <= x1_q;
			out_short_q  <= x2_q;
			out_colour_q <= colour_q;
			out_last_q   <= 1'b1;
		end
	end

	assign span.valid        = out_valid_q;
	assign span.span_row     = out_row_q;
	assign span.span_long_x  = out_long_q;
	assign span.span_short_x = out_short_q;
	assign span.span_colour  = out_colour_q;
	assign span.span_last    = out_last_q;

	assign sts.in_fire   = in_fire;
	assign sts.y01_eq    = y0_q == y1_q;
	assign sts.y12_eq    = y1_q == y2_q;
	assign sts.row_at_y1 = row_q == y1_q;
	assign sts.row_at_y2 = row_q == y2_q;
	assign sts.walk_done = long_done && short_done;
	assign sts.out_free  = out_free;

	assign long_lo = (x0_q < x2_q) ? x0_q : x2_q;
	assign long_hi = (x0_q < x2_q) ? x2_q : x0_q;

	`TSR_ASSERT_IMPL(a_no_overwrite, cmd.emit || cmd.flat, !out_valid_q || span.ready,
		"span register loaded while a transaction is pending")
	`TSR_ASSERT_IMPL(a_row_bound, cmd.step, row_q <= y2_q, "walking past the bottom row")
	`TSR_ASSERT_IMPL(a_long_in_box, cmd.emit, long_held >= long_lo && long_held <= long_hi,
		"long edge left its bounding box")

endmodule

`default_nettype wire

[rtl/tsr_ctrl.sv]
// ----------------------------------------------------------------------------
// tsr_ctrl
// Sequencer: accept, edge setup, per-row walk and span emit, flat-bottom span.
// ----------------------------------------------------------------------------
`default_nettype none
`include "triangle_scanline_span_rasterizer_macros.svh"

module tsr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  tsr_pkg::tsr_sts_t sts,
	output tsr_pkg::tsr_cmd_t cmd
);
	import tsr_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_INIT = 5'b00010,
		S_WALK = 5'b00100,
		S_EMIT = 5'b01000,
		S_FLAT = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   upper_q, upper_d;

	always_comb begin
		state_d = state_q;
		upper_d = upper_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				cmd.accept = 1'b1;
				if (sts.in_fire) begin
					state_d = S_INIT;
				end
			end
			S_INIT: begin
				cmd.load_long = 1'b1;
				if (!sts.y01_eq) begin
					cmd.load_short_upper = 1'b1;
					upper_d = 1'b1;
					state_d = S_WALK;
				end else if (sts.y12_eq) begin
					state_d = S_FLAT;
				end else begin
					cmd.load_short_lower = 1'b1;
					upper_d = 1'b0;
					state_d = S_WALK;
				end
			end
			S_WALK: begin
				cmd.step = 1'b1;
				if (sts.walk_done) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.last = !upper_q && sts.row_at_y2;
					if (upper_q) begin
						if (!sts.row_at_y1) begin
							cmd.row_inc = 1'b1;
							state_d = S_WALK;
						end else if (sts.y12_eq) begin
							state_d = S_FLAT;
						end else begin
							cmd.load_short_lower = 1'b1;
							cmd.row_inc = 1'b1;
							upper_d = 1'b0;
							state_d = S_WALK;
						end
					end else if (sts.row_at_y2) begin
						state_d = S_IDLE;
					end else begin
						cmd.row_inc = 1'b1;
						state_d = S_WALK;
					end
				end
			end
			S_FLAT: begin
				if (sts.out_free) begin
					cmd.flat = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			upper_q <= 1'b0;
		end else begin
			state_q <= state_d;
			upper_q <= upper_d;
		end
	end

	`TSR_ASSERT_NEXT(a_fire_init, sts.in_fire, state_q == S_INIT,
		"accepted triangle did not go to setup")
	`TSR_ASSERT_NEXT(a_last_idle, cmd.emit && cmd.last, state_q == S_IDLE,
		"final span not followed by idle")
	`TSR_ASSERT_IMPL(a_last_lower, cmd.emit && cmd.last, !upper_q,
		"final span flagged in the upper half")

endmodule

`default_nettype wire

[rtl/triangle_scanline_span_rasterizer.sv]
// ----------------------------------------------------------------------------
// triangle_scanline_span_rasterizer
// Triangle to horizontal span conversion by Bresenham edge walking.
// ----------------------------------------------------------------------------
// Usage:
//  triangle: valid/ready channel, one transaction per triangle (three vertices
//    and a fill colour). Ready is high only while the block is idle.
//  span: valid/ready channel, one transaction per row from the top vertex to
//    the bottom one; span_last marks the final span of a triangle.
//  Sequence: a triangle is accepted and its edges are set up; then for each row
//    both edge walkers step in parallel, one Bresenham step per cycle while
//    walking, and the span register is loaded. A flat bottom adds an extra
//    span for its row.
//  The next triangle is accepted as soon as the last span sits in the output
//    register, while it still waits to be taken.
//  If a span is pending and span.ready is low the sequencer holds in its emit or
//    flat state; nothing is lost. Reset clears the sequencer and empties the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_scanline_span_rasterizer (
	input  logic       clk,
	input  logic       arst_n,
	tsr_tri_if.sink    triangle,
	tsr_span_if.source span
);
	import tsr_pkg::*;

	tsr_cmd_t cmd;
	tsr_sts_t sts;

	tsr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	tsr_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.triangle (triangle),
		.span     (span)
	);

endmodule

`default_nettype wire
